@@ rtl/pcp_pkg.sv @@
// pcp_pkg: shared types, constants and helper functions for the path code
// common prefix block. No dependencies.
`timescale 1ns / 1ps

package pcp_pkg;

  localparam int CODE_BITS   = 32;
  localparam int LEN_W       = 5;
  localparam int CNT_W       = $clog2(CODE_BITS) + 1;
  localparam int POS_W       = $clog2(CODE_BITS);
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CODE_BITS-1:0] path_code;
    logic                 last_in_set;
  } in_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] prefix_code;
    logic [LEN_W-1:0]     prefix_length;
  } out_t;

  // classified item handed from the front end to the back end
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic [LEN_W-1:0]     len;
    logic                 last;
  } item_t;

  // end-of-set record, consumed by the result stage
  typedef struct packed {
    logic                 pass;
    logic                 hit;
    logic [CODE_BITS-1:0] code;
    logic [CNT_W-1:0]     count;
  } fin_t;

  // path length: CODE_BITS minus position of the lowest bit differing from bit 0
  function automatic logic [LEN_W-1:0] pcp_path_len(input logic [CODE_BITS-1:0] c);
    logic [CODE_BITS-1:0] diff;
    logic [POS_W-1:0]     pos;
    diff = c ^ {CODE_BITS{c[0]}};
    pos  = '0;
    for (int i = CODE_BITS - 1; i >= 0; i--) begin
      if (diff[i]) begin
        pos = POS_W'(i);
      end
    end
    if (diff == '0) begin
      return '0;
    end
    return LEN_W'(CODE_BITS - int'(pos));
  endfunction

  // count of equal leading bits, from the msb down
  function automatic logic [CNT_W-1:0] pcp_leading_equal(input logic [CODE_BITS-1:0] a,
                                                         input logic [CODE_BITS-1:0] b);
    logic [CODE_BITS-1:0] diff;
    logic [CNT_W-1:0]     n;
    diff = a ^ b;
    n    = CNT_W'(CODE_BITS);
    for (int i = 0; i < CODE_BITS; i++) begin
      if (diff[i]) begin
        n = CNT_W'(CODE_BITS - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/pcp_front.sv @@
// pcp_front: input register that accepts codes and decodes their path length.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcp_pkg::in_t  in_data,
  output logic          push_valid,
  input  logic          push_ready,
  output pcp_pkg::item_t push_item
);
  import pcp_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r, item_nxt;
  logic  accept;

  assign in_ready   = !vld_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = vld_r;
  assign push_item  = item_r;

  always_comb begin
    item_nxt = item_r;
    if (accept) begin
      vld_nxt       = 1'b1;
      item_nxt.code = in_data.path_code;
      item_nxt.len  = pcp_path_len(in_data.path_code);
      item_nxt.last = in_data.last_in_set;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

@@ rtl/pcp_fifo.sv @@
// pcp_fifo: short queue of classified items between front and back end.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pcp_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pcp_pkg::item_t pop_item
);
  import pcp_pkg::*;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != COUNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/pcp_back.sv @@
// pcp_back: per-set running state, end-of-set record and result register.
// Depends on pcp_pkg.
`timescale 1ns / 1ps

module pcp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  pcp_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output pcp_pkg::out_t  out_data
);
  import pcp_pkg::*;

  logic                 start_r, start_nxt;
  logic                 anchor_seen_r, anchor_seen_nxt;
  logic [CODE_BITS-1:0] anchor_r, anchor_nxt;
  logic [CNT_W-1:0]     shortest_r, shortest_nxt;
  logic [CNT_W-1:0]     shared_r, shared_nxt;
  logic                 fin_vld_r, fin_vld_nxt;
  fin_t                 fin_r, fin_nxt;
  logic                 out_vld_r, out_vld_nxt;
  out_t                 out_r, out_nxt;

  logic                 out_free, fin_free, pop, is_path;
  logic [CNT_W-1:0]     len_ext, lead, shortest_upd, shared_upd, span;
  logic [CODE_BITS-1:0] anchor_upd, low_mask;
  logic                 seen_upd, tail_bit;
  logic [POS_W-1:0]     tail;
  fin_t                 fin_new;

  assign out_free  = !out_vld_r || out_ready;
  assign fin_free  = !fin_vld_r || out_free;
  assign pop       = q_valid && (!q_item.last || fin_free);
  assign q_ready   = !q_item.last || fin_free;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // running minimums for the item at the head of the queue
  always_comb begin
    is_path      = (q_item.len != '0);
    len_ext      = CNT_W'(q_item.len);
    lead         = pcp_leading_equal(q_item.code, anchor_r);
    shortest_upd = (is_path && len_ext < shortest_r) ? len_ext : shortest_r;
    shared_upd   = (is_path && anchor_seen_r && lead < shared_r) ? lead : shared_r;
    anchor_upd   = (is_path && !anchor_seen_r) ? q_item.code : anchor_r;
    seen_upd     = anchor_seen_r || is_path;
    span         = (shortest_upd < shared_upd) ? shortest_upd : shared_upd;

    fin_new.pass  = start_r;
    fin_new.hit   = !start_r && seen_upd && (span != '0) && (span < CNT_W'(CODE_BITS));
    fin_new.code  = start_r ? q_item.code : anchor_upd;
    fin_new.count = start_r ? len_ext : span;
  end

  always_comb begin
    start_nxt       = start_r;
    anchor_seen_nxt = anchor_seen_r;
    anchor_nxt      = anchor_r;
    shortest_nxt    = shortest_r;
    shared_nxt      = shared_r;
    if (pop) begin
      if (q_item.last) begin
        start_nxt       = 1'b1;
        anchor_seen_nxt = 1'b0;
        anchor_nxt      = '0;
        shortest_nxt    = '1;
        shared_nxt      = '1;
      end else begin
        start_nxt       = 1'b0;
        anchor_seen_nxt = seen_upd;
        anchor_nxt      = anchor_upd;
        shortest_nxt    = shortest_upd;
        shared_nxt      = shared_upd;
      end
    end

    fin_nxt = fin_r;
    if (pop && q_item.last) begin
      fin_vld_nxt = 1'b1;
      fin_nxt     = fin_new;
    end else if (fin_vld_r && out_free) begin
      fin_vld_nxt = 1'b0;
    end else begin
      fin_vld_nxt = fin_vld_r;
    end
  end

  // result stage: pass a single-code set through, re-encode a hit prefix with the complement fill, else give zero
  always_comb begin
    tail     = POS_W'(CODE_BITS - int'(fin_r.count));
    low_mask = {CODE_BITS{1'b1}} >> fin_r.count;
    tail_bit = fin_r.code[tail];
    out_nxt  = out_r;
    if (fin_vld_r && out_free) begin
      out_vld_nxt = 1'b1;
      if (fin_r.pass) begin
        out_nxt.prefix_code   = fin_r.code;
        out_nxt.prefix_length = LEN_W'(fin_r.count);
      end else if (fin_r.hit) begin
        out_nxt.prefix_code   = (fin_r.code & ~low_mask) | (tail_bit ? '0 : low_mask);
        out_nxt.prefix_length = LEN_W'(fin_r.count);
      end else begin
        out_nxt.prefix_code   = '0;
        out_nxt.prefix_length = '0;
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= 1'b1;
      anchor_seen_r <= 1'b0;
      anchor_r      <= '0;
      shortest_r    <= '1;
      shared_r      <= '1;
      fin_vld_r     <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      start_r       <= start_nxt;
      anchor_seen_r <= anchor_seen_nxt;
      anchor_r      <= anchor_nxt;
      shortest_r    <= shortest_nxt;
      shared_r      <= shared_nxt;
      fin_vld_r     <= fin_vld_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
    out_r <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.last) |=> (start_r && !anchor_seen_r))
    else $error("set state not cleared after last item");

  a_anchor_len: assert property (@(posedge clk) disable iff (!rst_n)
    anchor_seen_r |-> (shortest_r < CNT_W'(CODE_BITS)))
    else $error("anchor present without a path length");

  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld_r && !out_free && !pop) |=> (fin_vld_r && $stable(fin_r)))
    else $error("end-of-set record lost while stalled");

  a_len_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.prefix_length != '0) |-> (out_r.prefix_code != '0))
    else $error("nonzero prefix length with zero code");
`endif

endmodule

@@ rtl/path_code_common_prefix_core.sv @@
// A last-in-set code passes the front register, the queue, fin_r and out_r before out_valid.
// Throughput: one code per cycle unless out_ready back-pressure stalls the back end.
// Front end (length decode) and back end (minimums, re-encode) run apart through a
// two-entry queue, so each side stalls on its own.
// Reset: synchronous active-low rst_n empties all stages and clears the per-set state.
// Depends on pcp_pkg, pcp_front, pcp_fifo, pcp_back.
`timescale 1ns / 1ps

module path_code_common_prefix_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pcp_pkg::out_t out_data
);
  import pcp_pkg::*;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  q_valid, q_ready;
  item_t q_item;

  pcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pcp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  pcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for path_code_common_prefix_core, a directed table then
// random code sets, checked against table answers or a behavioral common-prefix predictor.
// Depends on pcp_pkg and the RTL of path_code_common_prefix_core.
`timescale 1ns / 1ps

module testbench;
  import pcp_pkg::*;

  localparam int TOTAL_ITEMS     = 1750;
  localparam int CALM_TAIL       = 150;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DIR_ROWS        = 25;

  typedef struct {
    logic [31:0] code;
    bit          last;
    bit          typed;
    logic [31:0] exp_code;
    logic [4:0]  exp_len;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  in_t  in_data   = '0;
  out_t out_data;

  // per-set state of the predictor
  logic [31:0] pm_anchor;
  bit          pm_has_anchor;
  logic [31:0] pm_first;
  int unsigned pm_count;
  int unsigned pm_min_len;
  int unsigned pm_min_shared;

  out_t        expected_prefixes[$];
  out_t        want;
  int unsigned items_sent    = 0;
  int unsigned sets_sent     = 0;
  int unsigned results_seen  = 0;
  int unsigned errors        = 0;
  int unsigned idle_cycles   = 0;
  bit          drain_phase   = 1'b0;
  bit          tx_busy       = 1'b1;
  int unsigned stall_left    = 0;
  int unsigned stretch_left  = 0;
  bit          stretch_busy  = 1'b1;

  // known answers where they can be read off directly; other rows use the predictor
  dir_row_t directed [DIR_ROWS] = '{
    '{32'h00000000, 1'b1, 1'b1, 32'h00000000, 5'd0},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 5'd0},
    '{32'h80000000, 1'b1, 1'b1, 32'h80000000, 5'd1},
    '{32'h00000001, 1'b1, 1'b1, 32'h00000001, 5'd31},
    '{32'hFFFFFFFE, 1'b1, 1'b1, 32'hFFFFFFFE, 5'd31},
    '{32'h7FFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF, 5'd1},
    '{32'h00000000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 32'h00000000, 5'd0},
    '{32'h80000000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'h7FFFFFFF, 1'b1, 1'b1, 32'h00000000, 5'd0},
    '{32'hC0000000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'hA0000000, 1'b1, 1'b1, 32'h80000000, 5'd1},
    '{32'h00000001, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'h00000001, 1'b1, 1'b1, 32'h00000001, 5'd31},
    '{32'h00000000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'hC0000000, 1'b1, 1'b1, 32'hC0000000, 5'd2},
    '{32'h12345678, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'h12340000, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'h1234FFFF, 1'b1, 1'b0, 32'h0, 5'd0},
    '{32'h55555555, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'hAAAAAAAA, 1'b1, 1'b1, 32'h00000000, 5'd0},
    '{32'hFFFFFFFE, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'hFFFFFFFF, 1'b1, 1'b1, 32'hFFFFFFFE, 5'd31},
    '{32'h3C3C3C3C, 1'b0, 1'b0, 32'h0, 5'd0},
    '{32'h3C3C3C3D, 1'b1, 1'b0, 32'h0, 5'd0}
  };

  path_code_common_prefix_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // path length: 32 minus the index of the lowest bit that differs from bit 0
  function automatic int unsigned decode_len(input logic [31:0] c);
    logic [31:0] diff;
    int unsigned n;
    diff = c ^ {32{c[0]}};
    n    = 0;
    for (int i = 31; i >= 0; i--) begin
      if (diff[i]) begin
        n = 32 - i;
      end
    end
    return n;
  endfunction

  function automatic int unsigned count_shared(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    int unsigned n;
    diff = a ^ b;
    n    = 0;
    while (n < 32 && !diff[31 - n]) begin
      n++;
    end
    return n;
  endfunction

  // keep the top len bits, fill the rest with the complement of the last kept bit
  function automatic logic [31:0] encode_path(input logic [31:0] bits, input int unsigned len);
    logic [63:0] low;
    if (len == 0) begin
      return {32{bits[0]}};
    end
    low = (64'd1 << (32 - len)) - 64'd1;
    return (bits & ~low[31:0]) | (bits[32 - len] ? 32'h0 : low[31:0]);
  endfunction

  function automatic void clear_set_state();
    pm_anchor     = '0;
    pm_has_anchor = 1'b0;
    pm_first      = '0;
    pm_count      = 0;
    pm_min_len    = 63;
    pm_min_shared = 63;
  endfunction

  function automatic bit predict_prefix(input in_t item, output out_t res);
    int unsigned len;
    int unsigned shared;
    int unsigned j;
    int unsigned tail;
    logic [63:0] low;
    bit          single;
    len    = decode_len(item.path_code);
    single = (pm_count == 0);
    res    = '0;
    if (pm_count == 0) begin
      pm_first = item.path_code;
    end
    if (pm_count < 2) begin
      pm_count++;
    end
    if (len > 0) begin
      if (len < pm_min_len) begin
        pm_min_len = len;
      end
      if (!pm_has_anchor) begin
        pm_anchor     = item.path_code;
        pm_has_anchor = 1'b1;
      end else begin
        shared = count_shared(item.path_code, pm_anchor);
        if (shared < pm_min_shared) begin
          pm_min_shared = shared;
        end
      end
    end
    if (!item.last_in_set) begin
      return 1'b0;
    end
    if (single) begin
      res.prefix_code   = pm_first;
      res.prefix_length = 5'(len);
    end else if (pm_has_anchor) begin
      j = (pm_min_len < pm_min_shared) ? pm_min_len : pm_min_shared;
      if (j > 0 && j < 32) begin
        tail              = 32 - j;
        low               = (64'd1 << tail) - 64'd1;
        res.prefix_code   = (pm_anchor & ~low[31:0]) | (pm_anchor[tail] ? 32'h0 : low[31:0]);
        res.prefix_length = 5'(j);
      end
    end
    clear_set_state();
    return 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_code(input in_t item, input bit typed, input out_t typed_res);
    out_t        predicted;
    bit          produces;
    int unsigned gap;
    gap = 0;
    if (tx_busy && !drain_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = item;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    produces = predict_prefix(item, predicted);
    if (produces) begin
      expected_prefixes.insert(expected_prefixes.size(), typed ? typed_res : predicted);
      sets_sent++;
    end
    items_sent++;
    @(negedge clk);
  endtask

  // result side: random stall bursts inside busy stretches, none started while draining
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (stretch_left == 0) begin
        stretch_busy = $urandom_range(0, 1);
        stretch_left = $urandom_range(20, 200);
      end else begin
        stretch_left--;
      end
      if (stretch_busy && !drain_phase && $urandom_range(0, 5) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 14);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_prefixes.size() == 0) begin
        $error("unexpected result transfer: prefix_code %h prefix_length %0d",
               out_data.prefix_code, out_data.prefix_length);
        errors++;
      end else begin
        want = expected_prefixes.pop_front();
        if (out_data.prefix_code !== want.prefix_code) begin
          $error("prefix_code: expected %h, got %h", want.prefix_code, out_data.prefix_code);
          errors++;
        end
        if (out_data.prefix_length !== want.prefix_length) begin
          $error("prefix_length: expected %0d, got %0d",
                 want.prefix_length, out_data.prefix_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, expected_prefixes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_t         item;
    out_t        typed_res;
    logic [31:0] base;
    logic [31:0] bits;
    logic [63:0] keep;
    int unsigned set_size;
    int unsigned depth;
    int unsigned plen;
    bit          noisy;
    clear_set_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) begin
      item.path_code          = directed[i].code;
      item.last_in_set        = directed[i].last;
      typed_res.prefix_code   = directed[i].exp_code;
      typed_res.prefix_length = directed[i].exp_len;
      send_code(item, directed[i].typed, typed_res);
    end

    // random sets: members mostly share a prefix of a per-set base path
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= TOTAL_ITEMS - CALM_TAIL) begin
        drain_phase = 1'b1;
      end
      tx_busy  = ($urandom_range(0, 2) != 0);
      noisy    = ($urandom_range(0, 9) == 0);
      set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 24) : $urandom_range(1, 5);
      base     = $urandom;
      for (int k = 0; k < set_size; k++) begin
        if (noisy) begin
          bits = $urandom;
        end else if ($urandom_range(0, 1) != 0) begin
          bits = base;
        end else begin
          depth = $urandom_range(0, 31);
          keep  = ~((64'd1 << (32 - depth)) - 64'd1);
          bits  = (base & keep[31:0]) | ($urandom & ~keep[31:0]);
        end
        case ($urandom_range(0, 9))
          0: begin
            plen = 0;
          end
          1: begin
            plen = 31;
          end
          2: begin
            plen = 1;
          end
          default: begin
            plen = $urandom_range(1, 31);
          end
        endcase
        item.path_code   = noisy ? bits : encode_path(bits, plen);
        item.last_in_set = (k == set_size - 1);
        send_code(item, 1'b0, '0);
      end
    end
    in_valid = 1'b0;

    while (expected_prefixes.size() != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    $display("covered %0d codes (%0d from the directed table) in %0d sets", items_sent,
             DIR_ROWS, sets_sent);
    $display("checked %0d prefix results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
